FILE: hdl/clt_pkg.sv
package clt_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // default depth of the front/back queue, in entries
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CHAR       = 2'd0,
    KIND_TOKEN_END  = 2'd1,
    KIND_LINE_END   = 2'd2,
    KIND_BAD_ESCAPE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       token_is_name;
    logic       token_empty;
    logic       line_failed;
    logic       last;
  } result_t;

  // up to two results caused by one request
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

endpackage

FILE: hdl/clt_stream_if.sv
interface clt_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/clt_front.sv
module clt_front (
  input  logic              clk,
  input  logic              rst,
  clt_stream_if.sink        chars,
  input  logic              full,
  output logic              push,
  output clt_pkg::entry_t   entry
);

  logic in_quotes, escape_pending, token_has_chars, name_done, line_error;
  logic in_quotes_next, escape_pending_next, token_has_chars_next;
  logic name_done_next, line_error_next;
  logic accept;
  logic [1:0] cnt;
  clt_pkg::result_t r0, r1, res;
  clt_pkg::in_item_t it;

  assign chars.ready = !full;
  assign accept = chars.valid && !full;
  assign it = chars.data;

  always_comb begin
    in_quotes_next       = in_quotes;
    escape_pending_next  = escape_pending;
    token_has_chars_next = token_has_chars;
    name_done_next       = name_done;
    line_error_next      = line_error;
    cnt = 2'd0;
    r0  = '0;
    r1  = '0;
    res = '0;

    // byte phase: at most one result
    if (it.byte_valid && !line_error) begin
      res.token_is_name = !name_done;
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (it.byte_value == clt_pkg::CH_SPACE || it.byte_value == clt_pkg::CH_BACKSLASH ||
            it.byte_value == clt_pkg::CH_QUOTE) begin
          res.kind = clt_pkg::KIND_CHAR;
          res.char_value = it.byte_value;
          token_has_chars_next = 1'b1;
        end else if (it.byte_value == clt_pkg::CH_LOWER_N) begin
          res.kind = clt_pkg::KIND_CHAR;
          res.char_value = clt_pkg::CH_NEWLINE;
          token_has_chars_next = 1'b1;
        end else begin
          res.kind = clt_pkg::KIND_BAD_ESCAPE;
          res.char_value = it.byte_value;
          line_error_next = 1'b1;
        end
        cnt = 2'd1;
      end else if (it.byte_value == clt_pkg::CH_BACKSLASH) begin
        escape_pending_next = 1'b1;
      end else if (it.byte_value == clt_pkg::CH_QUOTE) begin
        in_quotes_next = !in_quotes;
      end else if (it.byte_value == clt_pkg::CH_SPACE && !in_quotes) begin
        if (token_has_chars) begin
          res.kind = clt_pkg::KIND_TOKEN_END;
          name_done_next = 1'b1;
          token_has_chars_next = 1'b0;
          cnt = 2'd1;
        end
      end else begin
        res.kind = clt_pkg::KIND_CHAR;
        res.char_value = it.byte_value;
        token_has_chars_next = 1'b1;
        cnt = 2'd1;
      end
      r0 = res;
    end

    // line end phase: dangling escape, then the line end itself
    if (it.end_of_line) begin
      res = '0;
      if (escape_pending_next && !line_error_next) begin
        res.kind = clt_pkg::KIND_BAD_ESCAPE;
        res.token_is_name = !name_done_next;
        line_error_next = 1'b1;
        r0 = res;
        cnt = 2'd1;
      end
      res = '0;
      res.kind          = clt_pkg::KIND_LINE_END;
      res.token_is_name = !name_done_next;
      res.token_empty   = !token_has_chars_next;
      res.line_failed   = line_error_next;
      if (cnt == 2'd0) begin
        r0 = res;
      end else begin
        r1 = res;
      end
      cnt = cnt + 2'd1;
      in_quotes_next       = 1'b0;
      escape_pending_next  = 1'b0;
      token_has_chars_next = 1'b0;
      name_done_next       = 1'b0;
      line_error_next      = 1'b0;
    end

    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;
  end

  assign push         = accept && (cnt != 2'd0);
  assign entry.first  = r0;
  assign entry.second = r1;
  assign entry.two    = (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes       <= 1'b0;
      escape_pending  <= 1'b0;
      token_has_chars <= 1'b0;
      name_done       <= 1'b0;
      line_error      <= 1'b0;
    end else if (accept) begin
      in_quotes       <= in_quotes_next;
      escape_pending  <= escape_pending_next;
      token_has_chars <= token_has_chars_next;
      name_done       <= name_done_next;
      line_error      <= line_error_next;
    end
  end

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && it.end_of_line) |=>
      !(in_quotes || escape_pending || token_has_chars || name_done || line_error))
    else $error("state not cleared after line end");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(in_quotes) && $stable(escape_pending) &&
                 $stable(token_has_chars) && $stable(name_done) && $stable(line_error)))
    else $error("state changed without a request");

endmodule

FILE: hdl/clt_queue.sv
module clt_queue #(
  parameter int DEPTH = clt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  clt_pkg::entry_t wr_entry,
  input  logic            pop,
  output clt_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  clt_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");

endmodule

FILE: hdl/clt_back.sv
module clt_back (
  input  logic            clk,
  input  logic            rst,
  input  clt_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  clt_stream_if.source    tokens
);

  logic             out_valid;
  clt_pkg::result_t out_data;
  logic             sel;   // second result of the head entry is next
  logic             load;

  assign load = !out_valid || tokens.ready;
  assign pop  = load && !empty && (sel || !head.two);

  assign tokens.valid = out_valid;
  assign tokens.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        out_data <= sel ? head.second : head.first;
        sel      <= !sel && head.two;
      end
    end
  end

  a_sel_has_entry: assert property (@(posedge clk) disable iff (rst) sel |-> !empty)
    else $error("second half selected with empty queue");

endmodule

FILE: hdl/command_line_tokenizer.sv
// Channel   Dir  Payload                                        Handshake
// chars     in   byte_value, byte_valid, end_of_line            valid/ready
// tokens    out  kind, char_value, token_is_name, token_empty,  valid/ready
//                line_failed, last
//
// One request per cycle enters; the front classifies it and updates the line
// state in the same cycle, writing 0 to 2 results into a QUEUE_DEPTH-entry queue.
// The back drains one result per cycle, unless stalled, through a registered
// output; two-result requests hold the back for both, so throughput is set by the
// single-result output port. Results are registered in the queue and at the
// output. Reset (rst, synchronous) clears line state, queue and output valid.
// chars.ready drops only while the queue is full; tokens stalls back up there.
module command_line_tokenizer #(
  parameter int QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  clt_stream_if.sink    chars,
  clt_stream_if.source  tokens
);

  // front -> queue -> back
  logic            push, pop, full, empty;
  clt_pkg::entry_t wr_entry, head;

  // Front: decode quotes, escapes and spaces, track the command name flag.
  clt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  // Queue decouples input stalls from output stalls.
  clt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // Back: serialize each entry's one or two results onto the output port.
  clt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule
